// ----- design/cms_pkg.sv -----
// ----------------------------------------------------------------------------
// cms_pkg: shared types and codes for the count-min sketch
// Request codes, controller states and the command/status structs that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package cms_pkg;
   localparam int HASH_FIELDS = 4;
   localparam int HASH_BITS   = 32;
   localparam int CFG_BITS    = 11;
   localparam int EST_BITS    = 32;

   typedef enum logic [1:0] {
      REQ_INC   = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_RD,
      ST_RDWAIT,
      ST_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;       // capture request, start modulo units
      logic clr_start;  // reset sweep address
      logic clr_step;   // write zero at sweep address, advance
      logic rd_start;   // reset row pointer, preset minimum
      logic rd_issue;   // read current row, advance
      logic wr_start;   // reset row pointer for write pass
      logic wr_step;    // conditional write of current row, advance
      logic res_load;   // load result register
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic clr_last;
      logic row_last;
      logic rd_pending;
      logic is_inc;
      logic is_clear;
   } status_type;
endpackage
`default_nettype wire

// ----- design/cms_ram.sv -----
// ----------------------------------------------------------------------------
// cms_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module cms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- design/cms_mod.sv -----
// ----------------------------------------------------------------------------
// cms_mod: iterative remainder unit
// Restoring division one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none
module cms_mod #(
   parameter int DBITS = 32,
   parameter int MBITS = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DBITS-1:0] dividend,
   input  wire logic [MBITS-1:0] divisor,
   output logic                  done,
   output logic      [MBITS-1:0] remainder
);
   localparam int CBITS = $clog2(DBITS + 1);

   logic [DBITS-1:0] quo_ff, quo_in;
   logic [MBITS:0]   rem_ff, rem_in;
   logic [MBITS-1:0] div_ff;
   logic [CBITS-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [MBITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[MBITS-1:0], quo_ff[DBITS-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CBITS'(DBITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DBITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CBITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done      = !busy_ff;
   assign remainder = rem_ff[MBITS-1:0];
endmodule
`default_nettype wire

// ----- design/cms_datapath.sv -----
// ----------------------------------------------------------------------------
// cms_datapath: counter memory, per-row remainders, minimum and update
// Reads the selected counter of each row in turn, keeps the minimum, then,
// for an increment, writes back incremented counters that equal it.
// ----------------------------------------------------------------------------
`default_nettype none
module cms_datapath
   import cms_pkg::*;
#(
   parameter int ROWS         = 4,
   parameter int MAX_BUCKETS  = 1024,
   parameter int COUNTER_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   input  wire logic [CFG_BITS-1:0]        buckets,
   input  wire logic [1:0]                 req_type,
   input  wire logic [HASH_FIELDS*HASH_BITS-1:0] hashes,
   output logic      [EST_BITS-1:0]        estimate
);
   localparam int BBITS = $clog2(MAX_BUCKETS);
   localparam int RBITS = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ABITS = $clog2(ROWS * MAX_BUCKETS);
   localparam int DEPTH = ROWS * MAX_BUCKETS;
   localparam int MODB  = (BBITS + 1 > CFG_BITS) ? BBITS + 1 : CFG_BITS;
   localparam logic [COUNTER_BITS-1:0] CMAX = '1;

   logic [MODB-1:0] eff_nb;
   logic [ROWS-1:0] mdone;
   logic [MODB-1:0] rem [ROWS];
   logic [BBITS-1:0] bkt_ff [ROWS];
   logic [1:0]      type_ff;
   logic [RBITS-1:0] row_ff, row_in;
   logic [ABITS-1:0] clr_ff;
   logic [RBITS-1:0] prow_ff;
   logic             pend_ff;
   logic [COUNTER_BITS-1:0] min_ff, min_in;
   logic [COUNTER_BITS-1:0] val_ff [ROWS];
   logic [EST_BITS-1:0] est_ff;
   logic             we;
   logic [ABITS-1:0] addr;
   logic [COUNTER_BITS-1:0] wdata, rdata, inc_min;

   // bucket count clamp: zero acts as one, oversize as the maximum
   always_comb begin
      if (buckets == '0) begin
         eff_nb = MODB'(1);
      end else if (MODB'(buckets) > MODB'(MAX_BUCKETS)) begin
         eff_nb = MODB'(MAX_BUCKETS);
      end else begin
         eff_nb = MODB'(buckets);
      end
   end

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      cms_mod #(.DBITS(HASH_BITS), .MBITS(MODB)) u_mod (
         .clock     (clock),
         .reset     (reset),
         .start     (cmd.load),
         .dividend  (hashes[(r % HASH_FIELDS)*HASH_BITS +: HASH_BITS]),
         .divisor   (eff_nb),
         .done      (mdone[r]),
         .remainder (rem[r])
      );
      always_ff @(posedge clock) begin
         bkt_ff[r] <= rem[r][BBITS-1:0];
      end
   end

   assign inc_min = (min_ff == CMAX) ? CMAX : min_ff + 1'b1;

   always_comb begin
      we    = 1'b0;
      wdata = '0;
      addr  = clr_ff;
      row_in = row_ff;
      min_in = min_ff;
      if (cmd.rd_start || cmd.wr_start) begin
         row_in = '0;
      end
      if (cmd.clr_step) begin
         we = 1'b1;
      end else if (cmd.rd_issue) begin
         addr   = ABITS'(row_ff) * ABITS'(MAX_BUCKETS) + ABITS'(bkt_ff[row_ff]);
         row_in = row_ff + 1'b1;
      end else if (cmd.wr_step) begin
         addr   = ABITS'(row_ff) * ABITS'(MAX_BUCKETS) + ABITS'(bkt_ff[row_ff]);
         we     = (val_ff[row_ff] == min_ff);
         wdata  = inc_min;
         row_in = row_ff + 1'b1;
      end
      if (cmd.rd_start) begin
         min_in = CMAX;
      end else if (pend_ff && rdata < min_ff) begin
         min_in = rdata;
      end
   end

   cms_ram #(.WIDTH(COUNTER_BITS), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         clr_ff  <= '0;
         row_ff  <= '0;
      end else begin
         pend_ff <= cmd.rd_issue;
         row_ff  <= row_in;
         if (cmd.clr_start) begin
            clr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
      prow_ff <= row_ff;
      min_ff  <= min_in;
      if (pend_ff) begin
         val_ff[prow_ff] <= rdata;
      end
      if (cmd.load) begin
         type_ff <= req_type;
      end
      if (cmd.res_load) begin
         if (type_ff == REQ_CLEAR) begin
            est_ff <= '0;
         end else if (type_ff == REQ_INC) begin
            est_ff <= EST_BITS'(inc_min);
         end else begin
            est_ff <= EST_BITS'(min_ff);
         end
      end
   end

   always_comb begin
      status.mod_done   = &mdone;
      status.clr_last   = (clr_ff == ABITS'(DEPTH - 1));
      status.row_last   = (row_ff == RBITS'(ROWS - 1));
      status.rd_pending = pend_ff;
      status.is_inc     = (type_ff == REQ_INC);
      status.is_clear   = (type_ff == REQ_CLEAR);
   end

   assign estimate = est_ff;
endmodule
`default_nettype wire

// ----- design/cms_ctrl.sv -----
// ----------------------------------------------------------------------------
// cms_ctrl: sequencer for the sketch
// Clearing sweep, remainder wait, read pass, write pass, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module cms_ctrl
   import cms_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic [1:0] req_type,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output cmd_type         cmd,
   input  wire status_type status
);
   state_type state_ff, state_in;
   logic      full_ff, full_in;
   logic      take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      take       = req_tvalid && req_tready;
      full_in    = full_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               cmd.load = 1'b1;
               if (req_type == REQ_CLEAR) begin
                  cmd.clr_start = 1'b1;
               end
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (status.is_clear) begin
               state_in = ST_CLEAR;
               // clear answers at once; sweep follows with input held off
               cmd.res_load = 1'b1;
               if (full_ff && !rsp_tready) begin
                  state_in = ST_MOD;
                  cmd.res_load = 1'b0;
               end else begin
                  full_in = 1'b1;
               end
            end else if (status.mod_done) begin
               cmd.rd_start = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            if (status.row_last) begin
               state_in = ST_RDWAIT;
            end
         end
         ST_RDWAIT: begin
            if (!status.rd_pending) begin
               cmd.wr_start = 1'b1;
               state_in = status.is_inc ? ST_WR : ST_OUT;
            end
         end
         ST_WR: begin
            cmd.wr_step = 1'b1;
            if (status.row_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!full_ff || rsp_tready) begin
               cmd.res_load = 1'b1;
               full_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = full_ff;
endmodule
`default_nettype wire

// ----- design/count_min_sketch_conservative.sv -----
// ----------------------------------------------------------------------------
// count_min_sketch_conservative: count-min sketch, conservative update
// Per-row hashes select counters; query gives the minimum, increment raises
// the counters at the minimum, clear zeroes all counters.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | tdata: hash_row_0..3 [127:0]; tuser: req_type [1:0]
//  rsp     | out | tdata: estimate [31:0]
//  csr     | in  | buckets_per_row [10:0]
// Query/increment: accept, remainder, one read per row, read drain, one write
//   per row (increment only), result; the pace is set by the bit-serial
//   remainder units and the single RAM port.
// Clear: accept, result, then a sweep that zeroes all ROWS*MAX_BUCKETS counters;
//   reset runs the same sweep. Input is held off during the sweep.
// The result register lets the next item enter while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
module count_min_sketch_conservative
   import cms_pkg::*;
#(
   parameter int ROWS         = 4,
   parameter int MAX_BUCKETS  = 1024,
   parameter int COUNTER_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // hash_row_0, hash_row_1, hash_row_2, hash_row_3
   input  wire logic [1:0]   req_tuser,   // req_type
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // estimate
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_data     // buckets_per_row in [10:0]
);
   cmd_type    cmd;
   status_type status;
   logic [CFG_BITS-1:0] buckets_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         buckets_ff <= CFG_BITS'(1024);
      end else if (csr_valid) begin
         buckets_ff <= csr_data[CFG_BITS-1:0];
      end
   end

   cms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cms_datapath #(
      .ROWS         (ROWS),
      .MAX_BUCKETS  (MAX_BUCKETS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .buckets  (buckets_ff),
      .req_type (req_tuser),
      .hashes   (req_tdata),
      .estimate (rsp_tdata)
   );
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: count-min sketch with conservative update
// Drives increment, query, clear and reserved requests with random hashes
// under several bucket counts, predicts every estimate with an own copy of
// the counter array, and checks each response in order. Both handshake sides
// idle at random; once the response side stalls long so the input backs up.
// ----------------------------------------------------------------------------
module tb_top;
   import cms_pkg::*;

   localparam int NROWS = 4;
   localparam int NBUCK = 1024;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      req_code_type kind;
      logic [3:0][31:0] hash;
   } sketch_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   count_min_sketch_conservative DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // predictor state
   logic [31:0] sketch_cnt [NROWS*NBUCK];
   logic [10:0] bucket_reg;

   sketch_req_type pending_reqs[$];
   logic [31:0] expected_est[$];
   int errors = 0;
   int cycles = 0;
   int hold_cycles = 0;
   int gap_cnt = 0;
   int stall_cnt = 0;

   function automatic logic [31:0] predict_estimate(sketch_req_type rq);
      int nb;
      int idx [NROWS];
      logic [31:0] mn;
      if (rq.kind == REQ_CLEAR) begin
         foreach (sketch_cnt[i]) sketch_cnt[i] = '0;
         return '0;
      end
      nb = (bucket_reg == 0) ? 1 : (bucket_reg > NBUCK) ? NBUCK : int'(bucket_reg);
      mn = '1;
      for (int r = 0; r < NROWS; r++) begin
         idx[r] = r * NBUCK + int'(rq.hash[r % 4] % nb);
         if (sketch_cnt[idx[r]] < mn) mn = sketch_cnt[idx[r]];
      end
      if (rq.kind != REQ_INC) return mn;
      for (int r = 0; r < NROWS; r++)
         if (sketch_cnt[idx[r]] == mn && mn != '1) sketch_cnt[idx[r]] = mn + 1;
      return (mn == '1) ? mn : mn + 1;
   endfunction

   function automatic int rand_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_est.push_back(predict_estimate(pending_reqs.pop_front()));
            gap_cnt = rand_gap();
         end
         if (gap_cnt > 0) begin
            gap_cnt--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !csr_valid) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_reqs[0].hash;
            req_tuser <= pending_reqs[0].kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_est.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected estimate %0d", rsp_tdata);
         end else begin
            logic [31:0] exp_v;
            exp_v = expected_est.pop_front();
            if (rsp_tdata !== exp_v) begin
               errors++;
               if (errors <= 10)
                  $display("estimate mismatch: expected %0d got %0d", exp_v, rsp_tdata);
            end
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         stall_cnt = rand_gap();
         rsp_tready <= (stall_cnt == 0);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [31:0] rand_hash();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_req(req_code_type k, logic [31:0] h0, logic [31:0] h1,
                          logic [31:0] h2, logic [31:0] h3);
      sketch_req_type rq;
      rq.kind = k;
      rq.hash = {h3, h2, h1, h0};
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_tvalid || expected_est.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_buckets(logic [10:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= {5'b0, v};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      bucket_reg = v;
   endtask

   task automatic random_phase(int n);
      logic [31:0] pool [8][4];
      for (int p = 0; p < 8; p++)
         for (int r = 0; r < 4; r++) pool[p][r] = rand_hash();
      for (int i = 0; i < n; i++) begin
         int k;
         int p;
         k = $urandom_range(0, 99);
         p = $urandom_range(0, 7);
         if (k < 55)
            add_req(REQ_INC, pool[p][0], pool[p][1], pool[p][2], pool[p][3]);
         else if (k < 85)
            add_req(REQ_QUERY, pool[p][0], pool[p][1], pool[p][2], pool[p][3]);
         else if (k < 93)
            add_req(REQ_INC, rand_hash(), rand_hash(), rand_hash(), rand_hash());
         else if (k < 97)
            add_req(REQ_NOP, rand_hash(), rand_hash(), rand_hash(), rand_hash());
         else
            add_req(REQ_CLEAR, rand_hash(), rand_hash(), rand_hash(), rand_hash());
      end
   endtask

   initial begin
      foreach (sketch_cnt[i]) sketch_cnt[i] = '0;
      bucket_reg = 11'd1024;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every request kind, reserved code
      add_req(REQ_QUERY, '0, '0, '0, '0);
      add_req(REQ_INC, '0, '0, '0, '0);
      add_req(REQ_INC, '1, '1, '1, '1);
      add_req(REQ_INC, '0, 32'd1, 32'd1024, 32'd1023);
      add_req(REQ_QUERY, '0, 32'd1, '0, '0);
      add_req(REQ_NOP, '0, '0, '0, '0);
      add_req(REQ_INC, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h7FFF_FFFF);
      add_req(REQ_QUERY, '1, '1, '1, '1);
      add_req(REQ_CLEAR, '1, '1, '1, '1);
      add_req(REQ_QUERY, '0, '0, '0, '0);
      wait_idle();
      // long receiver hold while the sender keeps offering; wait out the sweep
      while (!req_tready) @(posedge clock);
      hold_cycles = 800;
      for (int i = 0; i < 12; i++) add_req(REQ_INC, i, i, i, i);
      wait_idle();

      // bucket count zero acts as one: all hashes share one counter per row
      write_buckets(11'd0);
      add_req(REQ_INC, '1, 32'd7, '0, 32'd99);
      add_req(REQ_INC, 32'd3, '1, 32'd5, '0);
      add_req(REQ_QUERY, $urandom, $urandom, $urandom, $urandom);
      random_phase(150);
      wait_idle();
      write_buckets(11'd1);
      random_phase(100);
      wait_idle();
      write_buckets(11'd2047);  // above the row size: clipped
      random_phase(200);
      wait_idle();
      write_buckets(11'd3);
      random_phase(250);
      wait_idle();
      write_buckets(11'd1024);
      random_phase(200);
      wait_idle();
      write_buckets(11'd17);
      random_phase(200);
      wait_idle();

      if (errors == 0 && expected_est.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
design/cms_pkg.sv
design/cms_ram.sv
design/cms_mod.sv
design/cms_datapath.sv
design/cms_ctrl.sv
design/count_min_sketch_conservative.sv
tb/sv/tb_top.sv
